@@ hdl/tsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the triangle scanline rasterizer
// Coordinate format, command and result records, edge records, helpers.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int CoordBits    = 12;
  localparam int ScreenWidth  = 1024;
  localparam int ScreenHeight = 1024;
  localparam int ColorBits    = 24;
  localparam int DiffBits     = CoordBits + 1;
  localparam int ProdBits     = 2 * DiffBits;
  localparam int DivSteps     = DiffBits;
  localparam int CntBits      = $clog2(DivSteps + 1);
  localparam int InDataBits   = 6 * CoordBits + 32;
  localparam int OutDataBits  = ((3 * CoordBits + ColorBits + 7) / 8) * 8;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } edge_t;

  typedef struct packed {
    op_e                  op;
    logic                 cull;
    coord_t               ax;
    coord_t               ay;
    coord_t               bx;
    coord_t               by;
    coord_t               cx;
    coord_t               cy;
    logic [ColorBits-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic                 row_valid;
    logic                 culled;
    logic                 last_row;
    coord_t               row_y;
    coord_t               span_start;
    coord_t               span_end;
    logic [ColorBits-1:0] color;
  } res_t;

  // True when the point lies outside -20%..120% of the screen (5*v vs -S, 6*S).
  function automatic logic out_of_range(coord_t x, coord_t y);
    logic signed [CoordBits+3:0] x5;
    logic signed [CoordBits+3:0] y5;
    x5 = ((CoordBits+4)'(x) <<< 2) + (CoordBits+4)'(x);
    y5 = ((CoordBits+4)'(y) <<< 2) + (CoordBits+4)'(y);
    return (int'(x5) < -ScreenWidth) || (int'(x5) > 6 * ScreenWidth) ||
           (int'(y5) < -ScreenHeight) || (int'(y5) > 6 * ScreenHeight);
  endfunction

  // Orders the end points of an edge by y; equal y keeps the second point first.
  function automatic edge_t make_edge(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
    edge_t e;
    if (y1 < y2) begin
      e = '{x1: x1, y1: y1, x2: x2, y2: y2};
    end else begin
      e = '{x1: x2, y1: y2, x2: x1, y2: y1};
    end
    return e;
  endfunction

endpackage

@@ hdl/triangle_scanline_rasterizer_top.sv @@
// Timing: a load beat's result is registered in the output register when the engine pops it; an advance beat gives its
// row after the states dispatch, multiply, 13 division steps and finish, if a triangle is active.
// Throughput: one load per cycle while the output is not stalled; an advance holds the
// bit-serial division lanes that compute both edge x values of its row until that row is out.
// Reset: rst_ni clears the queue, the engine state and the output valid flag; no
// triangle is pending afterward.
// ----------------------------------------------------------------------------
// triangle_scanline_rasterizer_top: scanline triangle rasterizer
// Load beats set up a triangle (cull test, edge sort, long edge choice);
// advance beats emit one horizontal span per beat while a triangle is active.
// ----------------------------------------------------------------------------
module triangle_scanline_rasterizer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata from bit 0: ax, ay, bx, by_coord, cx, cy (12 bits each), tri_color (32, low 24 bits used).
  input  logic [tsr_pkg::InDataBits-1:0]  s_axis_tdata_i,
  // tuser: opcode (0 load, 1 advance).
  input  logic                            s_axis_tuser_i,
  // Output stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata from bit 0: row_y, span_start, span_end (12 bits each), span_color (24),
  // zero fill to 64 bits.
  output logic [tsr_pkg::OutDataBits-1:0] m_axis_tdata_o,
  // tuser from bit 0: row_valid, culled.
  output logic [1:0]                      m_axis_tuser_o,
  // tlast: last_row.
  output logic                            m_axis_tlast_o
);
  import tsr_pkg::*;

  // The front side classifies each beat and pushes a command into the queue;
  // the back side pops commands only when it can deliver their result.
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_in, q_out;
  res_t res;

  tsr_front u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  tsr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_out)
  );

  tsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Pack the result beat; the fill bits above the color stay zero.
  assign m_axis_tdata_o = OutDataBits'({res.color, res.span_end, res.span_start, res.row_y});
  assign m_axis_tuser_o = {res.culled, res.row_valid};
  assign m_axis_tlast_o = res.last_row;

endmodule

@@ hdl/tsr_fifo.sv @@
// ----------------------------------------------------------------------------
// tsr_fifo: two-entry command queue
// Decouples the input classifier from the edge walking engine.
// ----------------------------------------------------------------------------
module tsr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsr_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tsr_pkg::cmd_t pop_data_o
);
  import tsr_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/tsr_front.sv @@
// ----------------------------------------------------------------------------
// tsr_front: input classifier
// Unpacks an input beat, flags vertices outside -20%..120% of the screen and queues the command.
// ----------------------------------------------------------------------------
module tsr_front (
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [tsr_pkg::InDataBits-1:0] s_tdata_i,
  input  logic                           s_tuser_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output tsr_pkg::cmd_t                  q_data_o
);
  import tsr_pkg::*;

  coord_t ax, ay, bx, by, cx, cy;

  assign ax = s_tdata_i[0*CoordBits +: CoordBits];
  assign ay = s_tdata_i[1*CoordBits +: CoordBits];
  assign bx = s_tdata_i[2*CoordBits +: CoordBits];
  assign by = s_tdata_i[3*CoordBits +: CoordBits];
  assign cx = s_tdata_i[4*CoordBits +: CoordBits];
  assign cy = s_tdata_i[5*CoordBits +: CoordBits];

  assign s_tready_o = !q_full_i;
  assign q_push_o   = s_tvalid_i && !q_full_i;

  always_comb begin
    q_data_o.op    = op_e'(s_tuser_i);
    q_data_o.cull  = out_of_range(ax, ay) || out_of_range(bx, by) || out_of_range(cx, cy);
    q_data_o.ax    = ax;
    q_data_o.ay    = ay;
    q_data_o.bx    = bx;
    q_data_o.by    = by;
    q_data_o.cx    = cx;
    q_data_o.cy    = cy;
    q_data_o.color = s_tdata_i[6*CoordBits +: ColorBits];
  end

endmodule

@@ hdl/tsr_back.sv @@
// ----------------------------------------------------------------------------
// tsr_back: edge walking engine
// Sets up triangles, then for each row computes the x values of both edges with a common
// multiply state (a product for each edge) and two lanes of restoring division.
// ----------------------------------------------------------------------------
module tsr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  tsr_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output tsr_pkg::res_t res_o
);
  import tsr_pkg::*;

  back_state_e state_q, state_d;

  edge_t                long_q, long_d;
  edge_t                sh0_q, sh0_d;
  edge_t                sh1_q, sh1_d;
  logic                 pass_q, pass_d;
  coord_t               row_q, row_d;
  logic [ColorBits-1:0] color_q, color_d;
  logic                 active_q, active_d;
  res_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [DiffBits-1:0]  rem_a_q, rem_a_d, rem_b_q, rem_b_d;
  logic [DiffBits-1:0]  quo_a_q, quo_a_d, quo_b_q, quo_b_d;
  logic [DiffBits-1:0]  dv_a_q, dv_a_d, dv_b_q, dv_b_d;
  logic                 neg_a_q, neg_a_d, neg_b_q, neg_b_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;

  edge_t                e0, e1, e2, lng, s0, s1, cur_s;
  diff_t                len0, len1, len2, maxlen;
  logic [1:0]           lsel;
  logic                 slot_free;

  diff_t                dx_a, dy_a, dx_b, dy_b;
  logic signed [ProdBits-1:0] prod_a, prod_b;
  logic [ProdBits-1:0]  mag_a, mag_b;
  logic [DiffBits:0]    t_a, t_b;
  diff_t                qa, qb;
  coord_t               xa, xb;
  coord_t               next_row;

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign slot_free   = !out_valid_q || res_ready_i;
  assign cur_s       = pass_q ? sh1_q : sh0_q;

  // Triangle setup from the queued command.
  always_comb begin
    e0   = make_edge(q_data_i.ax, q_data_i.ay, q_data_i.bx, q_data_i.by);
    e1   = make_edge(q_data_i.bx, q_data_i.by, q_data_i.cx, q_data_i.cy);
    e2   = make_edge(q_data_i.cx, q_data_i.cy, q_data_i.ax, q_data_i.ay);
    len0 = DiffBits'(e0.y2) - DiffBits'(e0.y1);
    len1 = DiffBits'(e1.y2) - DiffBits'(e1.y1);
    len2 = DiffBits'(e2.y2) - DiffBits'(e2.y1);
    lsel   = 2'd0;
    maxlen = '0;
    if (len0 > maxlen) begin
      maxlen = len0;
    end
    if (len1 > maxlen) begin
      maxlen = len1;
      lsel   = 2'd1;
    end
    if (len2 > maxlen) begin
      lsel = 2'd2;
    end
    case (lsel)
      2'd1: begin
        lng = e1; s0 = e2; s1 = e0;
      end
      2'd2: begin
        lng = e2; s0 = e0; s1 = e1;
      end
      default: begin
        lng = e0; s0 = e1; s1 = e2;
      end
    endcase
  end

  // Row datapath: edge deltas, products, division steps, final x values.
  always_comb begin
    dx_a   = DiffBits'(long_q.x2) - DiffBits'(long_q.x1);
    dy_a   = DiffBits'(row_q) - DiffBits'(long_q.y1);
    dx_b   = DiffBits'(cur_s.x2) - DiffBits'(cur_s.x1);
    dy_b   = DiffBits'(row_q) - DiffBits'(cur_s.y1);
    prod_a = ProdBits'(dx_a) * ProdBits'(dy_a);
    prod_b = ProdBits'(dx_b) * ProdBits'(dy_b);
    mag_a  = prod_a[ProdBits-1] ? ProdBits'(-prod_a) : ProdBits'(prod_a);
    mag_b  = prod_b[ProdBits-1] ? ProdBits'(-prod_b) : ProdBits'(prod_b);
    t_a    = {rem_a_q, quo_a_q[DiffBits-1]};
    t_b    = {rem_b_q, quo_b_q[DiffBits-1]};
    qa     = neg_a_q ? -diff_t'(quo_a_q) : diff_t'(quo_a_q);
    qb     = neg_b_q ? -diff_t'(quo_b_q) : diff_t'(quo_b_q);
    xa     = long_q.x1 + qa[CoordBits-1:0];
    xb     = cur_s.x1 + qb[CoordBits-1:0];
    next_row = row_q + CoordBits'(1);
  end

  always_comb begin
    state_d     = state_q;
    long_d      = long_q;
    sh0_d       = sh0_q;
    sh1_d       = sh1_q;
    pass_d      = pass_q;
    row_d       = row_q;
    color_d     = color_q;
    active_d    = active_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    rem_a_d     = rem_a_q;
    rem_b_d     = rem_b_q;
    quo_a_d     = quo_a_q;
    quo_b_d     = quo_b_q;
    dv_a_d      = dv_a_q;
    dv_b_d      = dv_b_q;
    neg_a_d     = neg_a_q;
    neg_b_d     = neg_b_q;
    cnt_d       = cnt_q;
    q_pop_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i && slot_free) begin
          if (q_data_i.op == OP_LOAD) begin
            q_pop_o     = 1'b1;
            out_d       = '0;
            out_valid_d = 1'b1;
            if (q_data_i.cull) begin
              active_d     = 1'b0;
              out_d.culled = 1'b1;
            end else begin
              long_d  = lng;
              sh0_d   = s0;
              sh1_d   = s1;
              color_d = q_data_i.color;
              if (lng.y2 > lng.y1 && s0.y2 > s0.y1) begin
                pass_d   = 1'b0;
                row_d    = s0.y1;
                active_d = 1'b1;
              end else if (lng.y2 > lng.y1 && s1.y2 > s1.y1) begin
                pass_d   = 1'b1;
                row_d    = s1.y1;
                active_d = 1'b1;
              end else begin
                active_d     = 1'b0;
                out_d.culled = 1'b1;
              end
            end
          end else if (!active_q) begin
            q_pop_o     = 1'b1;
            out_d       = '0;
            out_valid_d = 1'b1;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        neg_a_d = prod_a[ProdBits-1];
        neg_b_d = prod_b[ProdBits-1];
        rem_a_d = mag_a[ProdBits-1 -: DiffBits];
        rem_b_d = mag_b[ProdBits-1 -: DiffBits];
        quo_a_d = mag_a[DiffBits-1:0];
        quo_b_d = mag_b[DiffBits-1:0];
        dv_a_d  = DiffBits'(long_q.y2) - DiffBits'(long_q.y1);
        dv_b_d  = DiffBits'(cur_s.y2) - DiffBits'(cur_s.y1);
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (t_a >= {1'b0, dv_a_q}) begin
          rem_a_d = DiffBits'(t_a - {1'b0, dv_a_q});
          quo_a_d = {quo_a_q[DiffBits-2:0], 1'b1};
        end else begin
          rem_a_d = t_a[DiffBits-1:0];
          quo_a_d = {quo_a_q[DiffBits-2:0], 1'b0};
        end
        if (t_b >= {1'b0, dv_b_q}) begin
          rem_b_d = DiffBits'(t_b - {1'b0, dv_b_q});
          quo_b_d = {quo_b_q[DiffBits-2:0], 1'b1};
        end else begin
          rem_b_d = t_b[DiffBits-1:0];
          quo_b_d = {quo_b_q[DiffBits-2:0], 1'b0};
        end
        cnt_d = cnt_q + CntBits'(1);
        if (cnt_q == CntBits'(DivSteps - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          q_pop_o          = 1'b1;
          out_valid_d      = 1'b1;
          out_d.row_valid  = 1'b1;
          out_d.culled     = 1'b0;
          out_d.row_y      = row_q;
          out_d.span_start = (xa < xb) ? xa : xb;
          out_d.span_end   = (xa < xb) ? xb : xa;
          out_d.color      = color_q;
          out_d.last_row   = 1'b0;
          row_d            = next_row;
          if (next_row >= cur_s.y2) begin
            if (!pass_q && sh1_q.y2 > sh1_q.y1) begin
              pass_d = 1'b1;
              row_d  = sh1_q.y1;
            end else begin
              active_d       = 1'b0;
              out_d.last_row = 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      long_q      <= '0;
      sh0_q       <= '0;
      sh1_q       <= '0;
      pass_q      <= 1'b0;
      row_q       <= '0;
      color_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      long_q      <= long_d;
      sh0_q       <= sh0_d;
      sh1_q       <= sh1_d;
      pass_q      <= pass_d;
      row_q       <= row_d;
      color_q     <= color_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    rem_a_q <= rem_a_d;
    rem_b_q <= rem_b_d;
    quo_a_q <= quo_a_d;
    quo_b_q <= quo_b_d;
    dv_a_q  <= dv_a_d;
    dv_b_q  <= dv_b_d;
    neg_a_q <= neg_a_d;
    neg_b_q <= neg_b_d;
  end

endmodule
